@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, off while reset is high.
`define VDW_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next one.
`define VDW_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  `VDW_ASSERT(label, clk, rst, (pre) |=> (post), msg)

`endif

@@ hw/rtl/vdw_pkg.sv @@
`timescale 1ns / 1ps
package vdw_pkg;

  // Bitmap side limit default
  localparam int MAX_SIDE_DEFAULT = 128;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register map, one 32-bit word each
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_NOISE_FREQUENCY,
    REG_WARP_STRENGTH,
    REG_OFFSET_A_X,
    REG_OFFSET_A_Y,
    REG_OFFSET_B_X,
    REG_OFFSET_B_Y
  } cfg_reg_t;

  localparam logic [7:0]  RST_IMAGE_WIDTH     = 8'd64;
  localparam logic [7:0]  RST_IMAGE_HEIGHT    = 8'd64;
  localparam logic [15:0] RST_NOISE_FREQUENCY = 16'd2621;
  localparam logic [11:0] RST_WARP_STRENGTH   = 12'd1024;

  // Cell hash multipliers
  localparam logic [31:0] HASH_KX = 32'd374761393;
  localparam logic [31:0] HASH_KY = 32'd668265263;
  localparam logic [31:0] HASH_KM = 32'd1274126177;

  // Datapath widths
  localparam int SX_W  = 23;               // x * freq, unsigned
  localparam int P_W   = 25;               // noise coordinate, signed Q8.16
  localparam int G_W   = P_W - 16;         // cell index, signed
  localparam int EXT_W = P_W + 2;          // offset sum before narrowing
  localparam int EX_W  = 19;               // feature offset, signed Q.16
  localparam int D_W   = 37;               // squared distance, Q.32
  localparam int R_W   = (D_W + 1) / 2;    // distance, Q.16
  localparam int WS_W  = 12;               // warp strength Q4.8
  localparam int DISP_SHIFT = 24;
  localparam int WORLEY_LAT = 6;

  // One input item
  typedef struct packed {
    logic       cmd;
    logic [6:0] px;
    logic [6:0] py;
    logic [7:0] pval;
  } item_t;

endpackage

@@ hw/rtl/vdw_worley.sv @@
`timescale 1ns / 1ps
// Nearest squared feature distance over the 3x3 cells around (p, q).
// Six register stages: hash mix, hash multiply, offsets, squares, two min levels.
module vdw_worley (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [vdw_pkg::P_W-1:0] p,
  input  logic signed [vdw_pkg::P_W-1:0] q,
  output logic        [vdw_pkg::D_W-1:0] dist2
);
  import vdw_pkg::*;

  localparam int NC = 9;

  function automatic logic [D_W-1:0] min3(input logic [D_W-1:0] a, input logic [D_W-1:0] b,
                                          input logic [D_W-1:0] c);
    logic [D_W-1:0] m;
    m = (b < a) ? b : a;
    return (c < m) ? c : m;
  endfunction

  logic signed [G_W-1:0] ci, cj;
  logic signed [P_W-1:0] a_p, a_q, b_p, b_q;
  logic [D_W-1:0] d_sq [NC];
  logic [D_W-1:0] e_min [3];

  // Cell containing the point (floor of Q8.16)
  assign ci = p[P_W-1:16];
  assign cj = q[P_W-1:16];

  // Point carried alongside the hash stages
  always_ff @(posedge clk) begin
    if (en) begin
      a_p <= p;
      a_q <= q;
      b_p <= a_p;
      b_q <= a_q;
    end
  end

  // One lane per neighbor cell
  for (genvar K = 0; K < NC; K++) begin : g_lane
    localparam int DX = (K % 3) - 1;
    localparam int DY = (K / 3) - 1;

    logic signed [G_W-1:0]    gx, gy, a_gx, a_gy, b_gx, b_gy;
    logic [31:0]              hsum, a_h, b_h;
    logic [15:0]              h3;
    logic [16:0]              fx, fy;
    logic signed [EXT_W-1:0]  ex_w, ey_w;
    logic signed [EX_W-1:0]   c_ex, c_ey;
    logic signed [2*EX_W-1:0] sqx, sqy;

    always_comb begin
      gx   = ci + G_W'(DX);
      gy   = cj + G_W'(DY);
      hsum = 32'(gx) * HASH_KX + 32'(gy) * HASH_KY;
    end

    // Feature point fraction: hash byte * 257
    always_comb begin
      h3   = b_h[15:0] ^ b_h[31:16];
      fx   = {1'b0, h3[7:0], h3[7:0]};
      fy   = {1'b0, h3[15:8], h3[15:8]};
      ex_w = EXT_W'($signed({b_gx, 16'h0000})) + EXT_W'($signed(fx)) - EXT_W'(b_p);
      ey_w = EXT_W'($signed({b_gy, 16'h0000})) + EXT_W'($signed(fy)) - EXT_W'(b_q);
      sqx  = c_ex * c_ex;
      sqy  = c_ey * c_ey;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_gx     <= gx;
        a_gy     <= gy;
        a_h      <= hsum ^ (hsum >> 13);
        b_gx     <= a_gx;
        b_gy     <= a_gy;
        b_h      <= a_h * HASH_KM;
        c_ex     <= EX_W'(ex_w);
        c_ey     <= EX_W'(ey_w);
        d_sq[K]  <= D_W'(sqx) + D_W'(sqy);
      end
    end
  end

  // Minimum over nine, in two levels
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        e_min[g] <= min3(d_sq[3*g], d_sq[3*g+1], d_sq[3*g+2]);
      end
      dist2 <= min3(e_min[0], e_min[1], e_min[2]);
    end
  end

endmodule

@@ hw/rtl/vdw_isqrt.sv @@
`timescale 1ns / 1ps
// Floor square root, one result bit per register stage (R_W stages).
module vdw_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vdw_pkg::D_W-1:0]    radicand,
  output logic [vdw_pkg::R_W-1:0]    root
);
  import vdw_pkg::*;

  logic [2*R_W-1:0] v_in [R_W];
  logic [R_W+1:0]   r_in [R_W];
  logic [R_W-1:0]   q_in [R_W];
  logic [2*R_W-1:0] v_q  [R_W];
  logic [R_W+1:0]   r_q  [R_W];
  logic [R_W-1:0]   q_q  [R_W];

  // Stage inputs: radicand for the first, previous stage for the rest
  always_comb begin
    v_in[0] = (2*R_W)'(radicand);
    r_in[0] = '0;
    q_in[0] = '0;
    for (int i = 1; i < R_W; i++) begin
      v_in[i] = v_q[i-1];
      r_in[i] = r_q[i-1];
      q_in[i] = q_q[i-1];
    end
  end

  for (genvar I = 0; I < R_W; I++) begin : g_step
    logic [R_W+1:0] acc, trial;

    // Bring down two bits, try root*4+1
    always_comb begin
      acc   = {r_in[I][R_W-1:0], v_in[I][2*R_W-1 -: 2]};
      trial = {q_in[I], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[I] <= v_in[I] << 2;
        if (acc >= trial) begin
          r_q[I] <= acc - trial;
          q_q[I] <= {q_in[I][R_W-2:0], 1'b1};
        end else begin
          r_q[I] <= acc;
          q_q[I] <= {q_in[I][R_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = q_q[R_W-1];

endmodule

@@ hw/rtl/vdw_image_mem.sv @@
`timescale 1ns / 1ps
// Source bitmap store and last pipeline stage: writes land here in item order,
// queries read the displaced pixel with registered read data.
module vdw_image_mem #(
  parameter int MAX_SIDE = vdw_pkg::MAX_SIDE_DEFAULT
) (
  input  logic           clk,
  input  logic           en,
  input  logic           vld,
  input  vdw_pkg::item_t item,
  input  logic [7:0]     nx,
  input  logic [7:0]     ny,
  input  logic [7:0]     image_width,
  input  logic [7:0]     image_height,
  output logic [7:0]     sample,
  output logic           oob
);
  import vdw_pkg::*;

  localparam int CW = ($clog2(MAX_SIDE + 1) > 8) ? $clog2(MAX_SIDE + 1) : 8;
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

  logic [7:0]    mem [MAX_SIDE * MAX_SIDE];
  logic [CW-1:0] w_eff, h_eff;
  logic          wr_ok, rd_in;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rd_q;

  // Effective size and address checks
  always_comb begin
    w_eff = (CW'(image_width)  < CW'(MAX_SIDE)) ? CW'(image_width)  : CW'(MAX_SIDE);
    h_eff = (CW'(image_height) < CW'(MAX_SIDE)) ? CW'(image_height) : CW'(MAX_SIDE);
    wr_ok = vld && (item.cmd == CMD_WRITE) &&
            (CW'(item.px) < CW'(MAX_SIDE)) && (CW'(item.py) < CW'(MAX_SIDE));
    rd_in = (CW'(nx) < w_eff) && (CW'(ny) < h_eff);
    waddr = AW'(AW'(item.py) * AW'(MAX_SIDE) + AW'(item.px));
    raddr = rd_in ? AW'(AW'(ny) * AW'(MAX_SIDE) + AW'(nx)) : '0;
  end

  // Write port
  always_ff @(posedge clk) begin
    if (en && wr_ok) begin
      mem[waddr] <= item.pval;
    end
  end

  // Read port, output register
  always_ff @(posedge clk) begin
    if (en) begin
      rd_q <= mem[raddr];
      oob  <= !rd_in;
    end
  end

  assign sample = oob ? 8'h00 : rd_q;

endmodule

@@ hw/rtl/voronoi_displacement_warp_core.sv @@
`timescale 1ns / 1ps
// Channel   Dir  tdata                                   tuser
// s_axis    in   [6:0] pixel_x [13:7] pixel_y             command
//                [21:14] pixel_value [23:22] zero
// m_axis    out  [7:0] sample_value                       out_of_image
// apb       in   8 registers at 4*i, 32-bit words
//
// One item per cycle while no result is held; a query's result passes the six
// Worley stages and then the 19-stage square root.
// Writes travel the same pipeline and land in the bitmap at the last stage.
// Reset clears valid bits and loads register defaults; the bitmap is not cleared.
// A held result freezes the whole pipeline; s_tready drops only then.
module voronoi_displacement_warp_core #(
  parameter int MAX_SIDE = vdw_pkg::MAX_SIDE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [6:0] pixel_x, [13:7] pixel_y, [21:14] pixel_value
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] sample_value
  output logic        m_tuser,   // [0] out_of_image
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vdw_pkg::*;

  localparam int SQ_IDX   = 2 + WORLEY_LAT + R_W;
  localparam int DISP_IDX = SQ_IDX + 1;
  localparam int OUT_IDX  = DISP_IDX + 1;

  logic [7:0]         image_width, image_height;
  logic [15:0]        noise_frequency;
  logic [WS_W-1:0]    warp_strength;
  logic signed [15:0] offset_a_x, offset_a_y, offset_b_x, offset_b_y;
  cfg_reg_t           reg_sel;

  logic               adv;
  logic [OUT_IDX:0]   vld;
  item_t              item_q [OUT_IDX+1];
  item_t              s_item;
  logic [SX_W-1:0]    sx, sy;
  logic signed [P_W-1:0] pa, qa, pb, qb;
  logic [D_W-1:0]     dist2_a, dist2_b;
  logic [R_W-1:0]     root_a, root_b;
  logic [R_W+WS_W-1:0] prod_x, prod_y;
  logic [7:0]         nx, ny;
  logic [7:0]         sample;
  logic               oob;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= RST_IMAGE_WIDTH;
      image_height    <= RST_IMAGE_HEIGHT;
      noise_frequency <= RST_NOISE_FREQUENCY;
      warp_strength   <= RST_WARP_STRENGTH;
      offset_a_x      <= '0;
      offset_a_y      <= '0;
      offset_b_x      <= '0;
      offset_b_y      <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_IMAGE_WIDTH:     image_width     <= pwdata[7:0];
        REG_IMAGE_HEIGHT:    image_height    <= pwdata[7:0];
        REG_NOISE_FREQUENCY: noise_frequency <= pwdata[15:0];
        REG_WARP_STRENGTH:   warp_strength   <= pwdata[WS_W-1:0];
        REG_OFFSET_A_X:      offset_a_x      <= pwdata[15:0];
        REG_OFFSET_A_Y:      offset_a_y      <= pwdata[15:0];
        REG_OFFSET_B_X:      offset_b_x      <= pwdata[15:0];
        REG_OFFSET_B_Y:      offset_b_y      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:     prdata = 32'(image_width);
      REG_IMAGE_HEIGHT:    prdata = 32'(image_height);
      REG_NOISE_FREQUENCY: prdata = 32'(noise_frequency);
      REG_WARP_STRENGTH:   prdata = 32'(warp_strength);
      REG_OFFSET_A_X:      prdata = 32'(unsigned'(offset_a_x));
      REG_OFFSET_A_Y:      prdata = 32'(unsigned'(offset_a_y));
      REG_OFFSET_B_X:      prdata = 32'(unsigned'(offset_b_x));
      REG_OFFSET_B_Y:      prdata = 32'(unsigned'(offset_b_y));
      default:             prdata = '0;
    endcase
  end

  // Whole pipeline advances unless a result is held
  assign adv      = !(m_tvalid && !m_tready);
  assign s_tready = adv;
  assign s_item   = '{cmd: s_tuser, px: s_tdata[6:0], py: s_tdata[13:7],
                      pval: s_tdata[21:14]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[OUT_IDX-1:0], s_tvalid};
    end
  end

  // Item fields travel with the valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      item_q[0] <= s_item;
      for (int k = 1; k <= OUT_IDX; k++) begin
        item_q[k] <= item_q[k-1];
      end
    end
  end

  // Scale into noise space, then add offsets
  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= SX_W'(item_q[0].px) * SX_W'(noise_frequency);
      sy <= SX_W'(item_q[0].py) * SX_W'(noise_frequency);
      pa <= $signed({2'b00, sx}) + P_W'(offset_a_x);
      qa <= $signed({2'b00, sy}) + P_W'(offset_a_y);
      pb <= $signed({2'b00, sy}) + P_W'(offset_b_x);
      qb <= $signed({2'b00, sx}) + P_W'(offset_b_y);
    end
  end

  vdw_worley u_worley_a (.clk(clk), .en(adv), .p(pa), .q(qa), .dist2(dist2_a));
  vdw_worley u_worley_b (.clk(clk), .en(adv), .p(pb), .q(qb), .dist2(dist2_b));

  vdw_isqrt u_isqrt_a (.clk(clk), .en(adv), .radicand(dist2_a), .root(root_a));
  vdw_isqrt u_isqrt_b (.clk(clk), .en(adv), .radicand(dist2_b), .root(root_b));

  // Displacement: distance * strength, integer part
  always_comb begin
    prod_x = R_W'(root_a) * (R_W+WS_W)'(warp_strength);
    prod_y = R_W'(root_b) * (R_W+WS_W)'(warp_strength);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nx <= 8'(item_q[SQ_IDX].px) + 8'(prod_x >> DISP_SHIFT);
      ny <= 8'(item_q[SQ_IDX].py) + 8'(prod_y >> DISP_SHIFT);
    end
  end

  vdw_image_mem #(.MAX_SIDE(MAX_SIDE)) u_image_mem (
    .clk          (clk),
    .en           (adv),
    .vld          (vld[DISP_IDX]),
    .item         (item_q[DISP_IDX]),
    .nx           (nx),
    .ny           (ny),
    .image_width  (image_width),
    .image_height (image_height),
    .sample       (sample),
    .oob          (oob)
  );

  // Only queries give a result
  assign m_tvalid = vld[OUT_IDX] && (item_q[OUT_IDX].cmd == CMD_QUERY);
  assign m_tdata  = sample;
  assign m_tuser  = oob;

endmodule

@@ hw/rtl/vdw_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks on the warp core.
module vdw_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       pready
);

  // Held result stays
  `VDW_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while held")

  // Held result keeps its payload
  `VDW_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "held result changed")

  // Outside samples read as zero
  `VDW_ASSERT(a_oob_zero, clk, rst, m_tvalid && m_tuser |-> m_tdata == 8'h00, "outside sample not zero")

  // Empty output never blocks input
  `VDW_ASSERT(a_ready_free, clk, rst, !m_tvalid |-> s_tready, "input stalled with no result pending")

  // Register port never waits
  `VDW_ASSERT(a_pready, clk, rst, pready, "pready low")

endmodule

bind voronoi_displacement_warp_core vdw_checker u_vdw_checker (.*);
